// ----- hdl/bounded_fifo_overflow_policy_core_assert.svh -----
// assertion macros for the bounded fifo core
`ifndef BOUNDED_FIFO_OVERFLOW_POLICY_CORE_ASSERT_SVH
`define BOUNDED_FIFO_OVERFLOW_POLICY_CORE_ASSERT_SVH
`define BFOP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define BFOP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BFOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/bfop_pkg.sv -----
// shared constants and types for the bounded fifo core
`timescale 1ns / 1ps
package bfop_pkg;

  localparam int OP_W    = 2;
  localparam int PRI_W   = 2;
  localparam int MODE_W  = 2;
  localparam int QLEN_W  = 5;
  localparam int PCT_W   = 7;
  localparam int FILL_W  = 5;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  localparam logic [MODE_W-1:0] MODE_DROP_OLDEST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DROP_NEWEST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DROP_PRIO   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HOLD        = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_QLEN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MODE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WPCT = 2'd2;

  localparam logic [QLEN_W-1:0] QLEN_RST = 5'd16;
  localparam logic [MODE_W-1:0] MODE_RST = MODE_DROP_OLDEST;
  localparam logic [PCT_W-1:0]  WPCT_RST = 7'd80;
  localparam logic [PCT_W-1:0]  PCT_SCALE = 7'd100;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_SCAN,
    S_MOVE,
    S_APPEND,
    S_DONE
  } state_t;

endpackage

// ----- hdl/bfop_if.sv -----
// request and result channel interfaces
`timescale 1ns / 1ps
interface bfop_in_if #(parameter int DATA_WIDTH = 32);
  import bfop_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [DATA_WIDTH-1:0] payload;
  logic [PRI_W-1:0]      priority_req;
  modport source (output valid, operation, payload, priority_req, input ready);
  modport sink   (input valid, operation, payload, priority_req, output ready);
endinterface

interface bfop_out_if #(parameter int DATA_WIDTH = 32);
  import bfop_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  accepted;
  logic [DATA_WIDTH-1:0] head_payload;
  logic [PRI_W-1:0]      head_priority;
  logic                  discarded;
  logic [DATA_WIDTH-1:0] discarded_payload;
  logic [PRI_W-1:0]      discarded_priority;
  logic [FILL_W-1:0]     fill_count;
  logic                  is_full;
  logic                  is_empty;
  logic                  near_capacity;
  modport source (output valid, accepted, head_payload, head_priority, discarded,
                  discarded_payload, discarded_priority, fill_count, is_full,
                  is_empty, near_capacity, input ready);
  modport sink   (input valid, accepted, head_payload, head_priority, discarded,
                  discarded_payload, discarded_priority, fill_count, is_full,
                  is_empty, near_capacity, output ready);
endinterface

// ----- hdl/bfop_ram.sv -----
// generic single-write single-read ram with registered read
`timescale 1ns / 1ps
module bfop_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/bounded_fifo_overflow_policy_core.sv -----
// bounded fifo with programmable length and overflow policy
// path: push with room, refused push and empty pop or peek go from S_IDLE straight
//   to S_DONE; pop, peek and drop-oldest push pass through S_HEAD first
// drop-lowest-priority push: S_SCAN reads up to min(count, SCAN_WINDOW) entries,
//   S_MOVE compacts, S_APPEND writes the item; scan and compaction share the single ram port
// one item at a time; the next beat is taken once the result is in the output register
// reset clears the head pointer, fill count, config and output valid; the ram is not cleared
`timescale 1ns / 1ps
`include "bounded_fifo_overflow_policy_core_assert.svh"
module bounded_fifo_overflow_policy_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SCAN_WINDOW = 8,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bfop_in_if.sink                     in_ch,
  bfop_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfop_pkg::CFG_AW-1:0] paddr,
  input  logic [bfop_pkg::CFG_DW-1:0] pwdata,
  output logic [bfop_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  import bfop_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = (CW > QLEN_W) ? CW : QLEN_W;
  localparam int PW = CW + PCT_W;
  localparam int MW = DATA_WIDTH + PRI_W;
  localparam logic [CW-1:0] SCAN_LIM =
    CW'((SCAN_WINDOW < QUEUE_DEPTH) ? SCAN_WINDOW : QUEUE_DEPTH);

  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] base,
                                           input logic [CW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(ofs);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // config registers
  logic [QLEN_W-1:0]    qlen_r;
  logic [MODE_W-1:0]    mode_r;
  logic [PCT_W-1:0]     wpct_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  // control state
  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic [CW-1:0] scan_pos_r, scan_pos_nxt;
  logic          scan_vld_r, scan_vld_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic [PRI_W-1:0] bestp_r, bestp_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic          pend_r, pend_nxt;

  // item and result under work
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [DATA_WIDTH-1:0] pay_r, pay_nxt;
  logic [PRI_W-1:0]      pri_r, pri_nxt;
  logic                  acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] hp_r, hp_nxt;
  logic [PRI_W-1:0]      hpr_r, hpr_nxt;
  logic                  disc_r, disc_nxt;
  logic [DATA_WIDTH-1:0] dp_r, dp_nxt;
  logic [PRI_W-1:0]      dpr_r, dpr_nxt;

  // output register
  logic                  out_valid_r;
  logic                  o_acc_r;
  logic [DATA_WIDTH-1:0] o_hp_r;
  logic [PRI_W-1:0]      o_hpr_r;
  logic                  o_disc_r;
  logic [DATA_WIDTH-1:0] o_dp_r;
  logic [PRI_W-1:0]      o_dpr_r;
  logic [FILL_W-1:0]     o_fill_r;
  logic                  o_full_r;
  logic                  o_empty_r;
  logic                  o_near_r;

  // ram port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata, mem_rdata;
  logic [DATA_WIDTH-1:0] rd_pay;
  logic [PRI_W-1:0]      rd_pri;

  logic [EW-1:0] qlen_ext;
  logic [CW-1:0] eff_len;
  logic [CW-1:0] scan_depth;
  logic          full_now;
  logic          near_now;
  logic          in_acc;
  logic          out_free;
  logic          load_out;
  logic          scan_done;
  logic          move_done;

  bfop_ram #(
    .WIDTH (MW),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_pay = mem_rdata[DATA_WIDTH-1:0];
  assign rd_pri = mem_rdata[MW-1 -: PRI_W];

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r <= QLEN_RST;
      mode_r <= MODE_RST;
      wpct_r <= WPCT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_QLEN: qlen_r <= pwdata[QLEN_W-1:0];
        REG_MODE: mode_r <= pwdata[MODE_W-1:0];
        REG_WPCT: wpct_r <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QLEN: prdata = CFG_DW'(qlen_r);
      REG_MODE: prdata = CFG_DW'(mode_r);
      REG_WPCT: prdata = CFG_DW'(wpct_r);
      default:  prdata = '0;
    endcase
  end

  // effective length and status
  assign qlen_ext = EW'(qlen_r);
  always_comb begin
    if (qlen_r == '0) begin
      eff_len = CW'(1);
    end else if (qlen_ext > EW'(QUEUE_DEPTH)) begin
      eff_len = CW'(QUEUE_DEPTH);
    end else begin
      eff_len = CW'(qlen_ext);
    end
  end

  assign full_now   = count_r >= eff_len;
  assign near_now   = (PW'(count_r) * PW'(PCT_SCALE)) >= (PW'(wpct_r) * PW'(eff_len));
  assign scan_depth = (count_r < SCAN_LIM) ? count_r : SCAN_LIM;
  assign scan_done  = (scan_idx_r == scan_depth) && !scan_vld_r;
  assign move_done  = (rd_r == count_r) && !pend_r;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign load_out = (state_r == S_DONE) && out_free;

  assign in_ch.ready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.operation == OP_PUSH) begin
            if (!full_now) begin
              state_nxt = S_DONE;
            end else if (mode_r == MODE_DROP_OLDEST) begin
              state_nxt = S_HEAD;
            end else if (mode_r == MODE_DROP_PRIO) begin
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_DONE;
            end
          end else if ((in_ch.operation == OP_POP || in_ch.operation == OP_PEEK) &&
                       count_r != '0) begin
            state_nxt = S_HEAD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_HEAD: state_nxt = S_DONE;
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        if (move_done) begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    scan_pos_nxt = scan_pos_r;
    scan_vld_nxt = scan_vld_r;
    best_nxt     = best_r;
    bestp_nxt    = bestp_r;
    rd_nxt       = rd_r;
    wr_nxt       = wr_r;
    pend_nxt     = pend_r;
    op_nxt       = op_r;
    pay_nxt      = pay_r;
    pri_nxt      = pri_r;
    acc_nxt      = acc_r;
    hp_nxt       = hp_r;
    hpr_nxt      = hpr_r;
    disc_nxt     = disc_r;
    dp_nxt       = dp_r;
    dpr_nxt      = dpr_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_ch.operation;
          pay_nxt      = in_ch.payload;
          pri_nxt      = in_ch.priority_req;
          acc_nxt      = 1'b0;
          hp_nxt       = '0;
          hpr_nxt      = '0;
          disc_nxt     = 1'b0;
          dp_nxt       = '0;
          dpr_nxt      = '0;
          scan_idx_nxt = '0;
          scan_vld_nxt = 1'b0;
          best_nxt     = '0;
          bestp_nxt    = '0;
          if (in_ch.operation == OP_PUSH) begin
            if (!full_now) begin
              mem_we    = 1'b1;
              mem_waddr = slot_f(head_r, count_r);
              mem_wdata = {in_ch.priority_req, in_ch.payload};
              count_nxt = count_r + CW'(1);
              acc_nxt   = 1'b1;
            end else begin
              case (mode_r)
                MODE_DROP_OLDEST: begin
                  mem_re    = 1'b1;
                  mem_raddr = head_r;
                end
                MODE_DROP_NEWEST: begin
                  disc_nxt = 1'b1;
                  dp_nxt   = in_ch.payload;
                  dpr_nxt  = in_ch.priority_req;
                end
                default: ;
              endcase
            end
          end else if ((in_ch.operation == OP_POP || in_ch.operation == OP_PEEK) &&
                       count_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = head_r;
          end
        end
      end
      S_HEAD: begin
        acc_nxt = 1'b1;
        if (op_r == OP_PUSH) begin
          disc_nxt  = 1'b1;
          dp_nxt    = rd_pay;
          dpr_nxt   = rd_pri;
          mem_we    = 1'b1;
          mem_waddr = slot_f(head_r, count_r);
          mem_wdata = {pri_r, pay_r};
          head_nxt  = slot_f(head_r, CW'(1));
        end else begin
          hp_nxt  = rd_pay;
          hpr_nxt = rd_pri;
          if (op_r == OP_POP) begin
            head_nxt  = slot_f(head_r, CW'(1));
            count_nxt = count_r - CW'(1);
          end
        end
      end
      S_SCAN: begin
        if (scan_idx_r < scan_depth) begin
          mem_re       = 1'b1;
          mem_raddr    = slot_f(head_r, scan_idx_r);
          scan_idx_nxt = scan_idx_r + CW'(1);
          scan_pos_nxt = scan_idx_r;
          scan_vld_nxt = 1'b1;
        end else begin
          scan_vld_nxt = 1'b0;
        end
        // first entry with the greatest priority value wins
        if (scan_vld_r && (scan_pos_r == '0 || rd_pri > bestp_r)) begin
          best_nxt  = scan_pos_r;
          bestp_nxt = rd_pri;
          dp_nxt    = rd_pay;
          dpr_nxt   = rd_pri;
        end
        if (scan_done) begin
          disc_nxt = 1'b1;
          rd_nxt   = best_r + CW'(1);
          wr_nxt   = best_r;
          pend_nxt = 1'b0;
        end
      end
      S_MOVE: begin
        // shift later entries down by one, the read running ahead of the write
        if (rd_r < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = slot_f(head_r, rd_r);
          rd_nxt    = rd_r + CW'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = slot_f(head_r, wr_r);
          mem_wdata = mem_rdata;
          wr_nxt    = wr_r + CW'(1);
        end
      end
      S_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = slot_f(head_r, count_r - CW'(1));
        mem_wdata = {pri_r, pay_r};
        acc_nxt   = 1'b1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      scan_vld_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      scan_vld_r <= scan_vld_nxt;
      pend_r     <= pend_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    scan_pos_r <= scan_pos_nxt;
    best_r     <= best_nxt;
    bestp_r    <= bestp_nxt;
    rd_r       <= rd_nxt;
    wr_r       <= wr_nxt;
    op_r       <= op_nxt;
    pay_r      <= pay_nxt;
    pri_r      <= pri_nxt;
    acc_r      <= acc_nxt;
    hp_r       <= hp_nxt;
    hpr_r      <= hpr_nxt;
    disc_r     <= disc_nxt;
    dp_r       <= dp_nxt;
    dpr_r      <= dpr_nxt;
    if (load_out) begin
      o_acc_r   <= acc_r;
      o_hp_r    <= hp_r;
      o_hpr_r   <= hpr_r;
      o_disc_r  <= disc_r;
      o_dp_r    <= dp_r;
      o_dpr_r   <= dpr_r;
      o_fill_r  <= FILL_W'(count_r);
      o_full_r  <= full_now;
      o_empty_r <= (count_r == '0);
      o_near_r  <= near_now;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.accepted           = o_acc_r;
  assign out_ch.head_payload       = o_hp_r;
  assign out_ch.head_priority      = o_hpr_r;
  assign out_ch.discarded          = o_disc_r;
  assign out_ch.discarded_payload  = o_dp_r;
  assign out_ch.discarded_priority = o_dpr_r;
  assign out_ch.fill_count         = o_fill_r;
  assign out_ch.is_full            = o_full_r;
  assign out_ch.is_empty           = o_empty_r;
  assign out_ch.near_capacity      = o_near_r;

  `BFOP_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(QUEUE_DEPTH), "fill count above depth")
  `BFOP_ASSERT_IMPLY(a_move_order, state_r == S_MOVE && pend_r, wr_r < rd_r, "compaction overrun")
  `BFOP_ASSERT_NEXT(a_refuse_keeps, in_acc && in_ch.operation == OP_PUSH && full_now && (mode_r == MODE_DROP_NEWEST || mode_r == MODE_HOLD), $stable(count_r) && $stable(head_r), "refused push moved queue")
  `BFOP_ASSERT_IMPLY(a_scan_best, state_r == S_SCAN && scan_done, best_r < scan_depth, "drop position outside window")

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the bounded fifo core: predicts each result beat and compares
`timescale 1ns / 1ps
module tb;
  import bfop_pkg::*;

  localparam int FIFO_DEPTH = 16;
  localparam int SCAN_SPAN  = 8;
  localparam int DW         = 32;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [DW-1:0]    payload;
    logic [PRI_W-1:0] prio;
  } fifo_req_t;

  typedef struct packed {
    logic              accepted;
    logic [DW-1:0]     head_payload;
    logic [PRI_W-1:0]  head_priority;
    logic              discarded;
    logic [DW-1:0]     discarded_payload;
    logic [PRI_W-1:0]  discarded_priority;
    logic [FILL_W-1:0] fill_count;
    logic              is_full;
    logic              is_empty;
    logic              near_capacity;
  } fifo_status_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  bfop_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  bfop_out_if #(.DATA_WIDTH(DW)) out_ch ();

  bounded_fifo_overflow_policy_core #(
    .QUEUE_DEPTH(FIFO_DEPTH),
    .SCAN_WINDOW(SCAN_SPAN),
    .DATA_WIDTH (DW)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // shadow of the queue and its registers
  logic [DW-1:0]     shadow_pay [FIFO_DEPTH];
  logic [PRI_W-1:0]  shadow_pri [FIFO_DEPTH];
  int                shadow_head = 0;
  int                shadow_count = 0;
  logic [QLEN_W-1:0] cfg_len = QLEN_RST;
  logic [MODE_W-1:0] cfg_mode = MODE_RST;
  logic [PCT_W-1:0]  cfg_pct = WPCT_RST;

  fifo_req_t    req_pending[$];
  fifo_status_t expected_status[$];
  fifo_req_t    cur_req;
  bit           in_fire = 0;
  bit           send_hold = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_req = 0;
  int           hold_left = 0;
  int           items_loaded = 0;
  int           items_accepted = 0;
  int           results_seen = 0;
  int           mismatches = 0;

  function automatic int slot_at(int k);
    return (shadow_head + k) % FIFO_DEPTH;
  endfunction

  function automatic void store_tail(logic [DW-1:0] pay, logic [PRI_W-1:0] pri);
    shadow_pay[slot_at(shadow_count)] = pay;
    shadow_pri[slot_at(shadow_count)] = pri;
    shadow_count++;
  endfunction

  function automatic void take_oldest(output logic [DW-1:0] pay, output logic [PRI_W-1:0] pri);
    pay = shadow_pay[shadow_head];
    pri = shadow_pri[shadow_head];
    shadow_head = (shadow_head + 1) % FIFO_DEPTH;
    shadow_count--;
  endfunction

  function automatic fifo_status_t fifo_predict(fifo_req_t r);
    fifo_status_t res;
    int len, span, best, i;
    logic [PRI_W-1:0] best_pri;
    res = '0;
    len = (cfg_len == 0) ? 1 : (int'(cfg_len) > FIFO_DEPTH) ? FIFO_DEPTH : int'(cfg_len);
    case (r.op)
      OP_PUSH: begin
        if (shadow_count < len) begin
          store_tail(r.payload, r.prio);
          res.accepted = 1'b1;
        end else begin
          case (cfg_mode)
            MODE_DROP_OLDEST: begin
              take_oldest(res.discarded_payload, res.discarded_priority);
              res.discarded = 1'b1;
              store_tail(r.payload, r.prio);
              res.accepted = 1'b1;
            end
            MODE_DROP_NEWEST: begin
              res.discarded = 1'b1;
              res.discarded_payload = r.payload;
              res.discarded_priority = r.prio;
            end
            MODE_DROP_PRIO: begin
              span = (shadow_count < SCAN_SPAN) ? shadow_count : SCAN_SPAN;
              best = 0;
              best_pri = '0;
              for (i = 0; i < span; i++) begin
                if (shadow_pri[slot_at(i)] > best_pri) begin
                  best_pri = shadow_pri[slot_at(i)];
                  best = i;
                end
              end
              res.discarded_payload = shadow_pay[slot_at(best)];
              res.discarded_priority = shadow_pri[slot_at(best)];
              for (i = best; i + 1 < shadow_count; i++) begin
                shadow_pay[slot_at(i)] = shadow_pay[slot_at(i + 1)];
                shadow_pri[slot_at(i)] = shadow_pri[slot_at(i + 1)];
              end
              shadow_count--;
              res.discarded = 1'b1;
              store_tail(r.payload, r.prio);
              res.accepted = 1'b1;
            end
            default: ;
          endcase
        end
      end
      OP_POP, OP_PEEK: begin
        if (shadow_count > 0) begin
          res.accepted = 1'b1;
          if (r.op == OP_POP) begin
            take_oldest(res.head_payload, res.head_priority);
          end else begin
            res.head_payload = shadow_pay[shadow_head];
            res.head_priority = shadow_pri[shadow_head];
          end
        end
      end
      default: ;
    endcase
    res.fill_count = FILL_W'(shadow_count);
    res.is_full = (shadow_count >= len);
    res.is_empty = (shadow_count == 0);
    res.near_capacity = (shadow_count * 100 >= int'(cfg_pct) * len);
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("tb: result beat %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [DW-1:0] got, logic [DW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // input beat bookkeeping and prediction
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_status = {expected_status, fifo_predict(cur_req)};
      items_accepted++;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (req_pending.size() != 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
        cur_req = req_pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= cur_req.op;
        in_ch.payload <= cur_req.payload;
        in_ch.priority_req <= cur_req.prio;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    fifo_status_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.accepted = out_ch.accepted;
      got.head_payload = out_ch.head_payload;
      got.head_priority = out_ch.head_priority;
      got.discarded = out_ch.discarded;
      got.discarded_payload = out_ch.discarded_payload;
      got.discarded_priority = out_ch.discarded_priority;
      got.fill_count = out_ch.fill_count;
      got.is_full = out_ch.is_full;
      got.is_empty = out_ch.is_empty;
      got.near_capacity = out_ch.near_capacity;
      if (expected_status.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_status.pop_front();
        check_field("accepted", DW'(got.accepted), DW'(want.accepted));
        check_field("head_payload", got.head_payload, want.head_payload);
        check_field("head_priority", DW'(got.head_priority), DW'(want.head_priority));
        check_field("discarded", DW'(got.discarded), DW'(want.discarded));
        check_field("discarded_payload", got.discarded_payload, want.discarded_payload);
        check_field("discarded_priority", DW'(got.discarded_priority),
                    DW'(want.discarded_priority));
        check_field("fill_count", DW'(got.fill_count), DW'(want.fill_count));
        check_field("is_full", DW'(got.is_full), DW'(want.is_full));
        check_field("is_empty", DW'(got.is_empty), DW'(want.is_empty));
        check_field("near_capacity", DW'(got.near_capacity), DW'(want.near_capacity));
        results_seen++;
      end
    end
  end

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_QLEN: cfg_len = val[QLEN_W-1:0];
      REG_MODE: cfg_mode = val[MODE_W-1:0];
      REG_WPCT: cfg_pct = val[PCT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_cfg(int len, logic [MODE_W-1:0] mode, int pct);
    cfg_write(REG_QLEN, CFG_DW'(len));
    cfg_write(REG_MODE, CFG_DW'(mode));
    cfg_write(REG_WPCT, CFG_DW'(pct));
  endtask

  task automatic add_req(logic [OP_W-1:0] op, logic [DW-1:0] pay, logic [PRI_W-1:0] pri);
    fifo_req_t r;
    r.op = op;
    r.payload = pay;
    r.prio = pri;
    req_pending = {req_pending, r};
    items_loaded++;
  endtask

  function automatic fifo_req_t random_req(int push_pct);
    fifo_req_t r;
    int pick;
    r.payload = $urandom;
    r.prio = PRI_W'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 3) r.op = OP_UNUSED;
    else if (pick < push_pct) r.op = OP_PUSH;
    else if ($urandom_range(3) == 0) r.op = OP_PEEK;
    else r.op = OP_POP;
    return r;
  endfunction

  task automatic drain_all();
    while (results_seen < items_loaded) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_random(int n, int send_idle, int recv_stall, int hold_cycles,
                            int pause_after);
    int k, bias, base;
    @(posedge clk);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    base = items_accepted;
    bias = 50;
    for (k = 0; k < n; k++) begin
      if (k % 16 == 0) begin
        case ($urandom_range(2))
          0: bias = 85;
          1: bias = 50;
          default: bias = 15;
        endcase
      end
      req_pending = {req_pending, random_req(bias)};
    end
    items_loaded += n;
    hold_req = hold_cycles;
    if (pause_after > 0) begin
      while (items_accepted < base + pause_after) @(posedge clk);
      send_hold = 1'b1;
      while (in_ch.valid || results_seen < items_accepted) @(negedge clk);
      @(posedge clk);
      send_hold = 1'b0;
    end
    drain_all();
  endtask

  initial begin
    int p;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_PUSH;
    in_ch.payload = '0;
    in_ch.priority_req = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, unused code and field extremes with reset settings
    add_req(OP_POP, 32'h0, 2'd0);
    add_req(OP_PEEK, 32'h0, 2'd0);
    add_req(OP_UNUSED, 32'hffff_ffff, 2'd3);
    add_req(OP_PUSH, 32'h0, 2'd0);
    add_req(OP_PUSH, 32'hffff_ffff, 2'd3);
    add_req(OP_PEEK, 32'h0, 2'd0);
    add_req(OP_POP, 32'h0, 2'd0);
    add_req(OP_POP, 32'h0, 2'd0);
    add_req(OP_POP, 32'h0, 2'd0);
    drain_all();

    // lowest priority drop picks the first of equal worst
    set_cfg(3, MODE_DROP_PRIO, 100);
    @(posedge clk);
    add_req(OP_PUSH, 32'h11, 2'd1);
    add_req(OP_PUSH, 32'h22, 2'd3);
    add_req(OP_PUSH, 32'h33, 2'd3);
    add_req(OP_PUSH, 32'h44, 2'd0);
    add_req(OP_PUSH, 32'h55, 2'd0);
    drain_all();

    set_cfg(3, MODE_DROP_NEWEST, 0);
    @(posedge clk);
    add_req(OP_PUSH, 32'h66, 2'd2);
    drain_all();

    set_cfg(3, MODE_HOLD, 127);
    @(posedge clk);
    add_req(OP_PUSH, 32'h77, 2'd1);
    add_req(OP_PEEK, 32'h0, 2'd0);
    drain_all();

    // length below the fill
    set_cfg(1, MODE_DROP_OLDEST, 50);
    @(posedge clk);
    add_req(OP_PUSH, 32'h88, 2'd3);
    add_req(OP_POP, 32'h0, 2'd0);
    drain_all();

    // length zero acts as one
    set_cfg(0, MODE_DROP_PRIO, 80);
    @(posedge clk);
    add_req(OP_PUSH, 32'h99, 2'd0);
    add_req(OP_POP, 32'h0, 2'd0);
    add_req(OP_POP, 32'h0, 2'd0);
    drain_all();

    // length above the depth
    set_cfg(31, MODE_DROP_OLDEST, 100);
    @(posedge clk);
    add_req(OP_PUSH, 32'h5a5a_a5a5, 2'd2);
    add_req(OP_POP, 32'h0, 2'd0);
    drain_all();

    set_cfg(16, MODE_DROP_PRIO, 80);
    run_random(150, 0, 0, 0, 0);
    set_cfg(4, MODE_DROP_OLDEST, 50);
    run_random(120, 68, 0, 0, 0);
    set_cfg(8, MODE_DROP_NEWEST, 100);
    run_random(120, 0, 68, 300, 0);
    set_cfg(1, MODE_HOLD, 0);
    run_random(100, 22, 22, 0, 0);
    set_cfg(0, MODE_DROP_PRIO, 127);
    run_random(80, 0, 0, 0, 0);
    set_cfg(31, MODE_DROP_PRIO, $urandom_range(127));
    run_random(120, 68, 0, 0, 60);
    for (p = 0; p < 3; p++) begin
      set_cfg($urandom_range(1, 16), MODE_W'($urandom_range(3)), $urandom_range(127));
      case (p)
        0: run_random(100, 0, 68, 0, 0);
        1: run_random(100, 22, 22, 0, 0);
        default: run_random(100, 0, 0, 0, 0);
      endcase
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bfop_pkg.sv
hdl/bfop_if.sv
hdl/bfop_ram.sv
hdl/bounded_fifo_overflow_policy_core.sv
tb/tb.sv
